// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; they compile to nothing in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every clock edge, suspended while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/hsl2rgb_pkg.sv -----
// Shared types and constants for the HSL to RGB converter.
`timescale 1ns / 1ps
package hsl2rgb_pkg;

    localparam int NUM_CH = 3;
    localparam int CHAN_W = 8;

    typedef logic [CHAN_W-1:0] chan_t;

    // Piece of the hue ramp a shifted hue falls into
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } hue_seg_t;

    // Advance strobes for the two back stages of a channel
    typedef struct packed {
        logic adv2;
        logic adv3;
    } stage_ctl_t;

endpackage

// ----- rtl/hsl2rgb_front.sv -----
// Stage one: q and p from saturation/lightness, hue shifts, wrap and ramp segment.
`timescale 1ns / 1ps
module hsl2rgb_front
    import hsl2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   adv1,
    input  chan_t                  hue,
    input  chan_t                  saturation,
    input  chan_t                  lightness,
    output logic [FRACTION_BITS:0] p_o,
    output logic [FRACTION_BITS:0] q_o,
    output logic [FRACTION_BITS:0] d_o,
    output logic [FRACTION_BITS:0] x_o   [NUM_CH],
    output hue_seg_t               seg_o [NUM_CH]
);

    localparam int F = FRACTION_BITS;
    localparam logic [F+2:0] ONE_W   = (F+3)'(1) << F;
    localparam logic [F+2:0] THREE_W = ONE_W + (ONE_W << 1);
    localparam logic [F+2:0] TWO_W   = ONE_W << 1;
    localparam logic [F+2:0] FOUR_W  = ONE_W << 2;

    logic [F-1:0]     h_fx, s_fx, l_fx;
    logic [15:0]      ls16;
    logic [2*F-1:0]   ls_wide;
    logic [F-1:0]     lsf;
    logic [F+1:0]     q_raw;
    logic [F:0]       q_c, p_c, l2;
    logic [F+2:0]     h3;
    logic [F+2:0]     t_w  [NUM_CH];
    logic [F+2:0]     w2;
    logic [F:0]       x_c  [NUM_CH];
    hue_seg_t         seg_c [NUM_CH];

    logic [F:0]       p_reg, q_reg, d_reg;
    logic [F:0]       x_reg [NUM_CH];
    hue_seg_t         seg_reg [NUM_CH];

    // Inputs are exact in the fixed-point format
    assign h_fx = {hue,        {(F-8){1'b0}}};
    assign s_fx = {saturation, {(F-8){1'b0}}};
    assign l_fx = {lightness,  {(F-8){1'b0}}};

    // floor(l*s) in fixed point from the 8x8 product
    assign ls16    = 16'(saturation * lightness);
    assign ls_wide = {ls16, {(2*F-16){1'b0}}};
    assign lsf     = ls_wide[2*F-1:F];

    // q and p, clamped to 0..1
    always_comb begin
        if (!lightness[7]) begin
            q_raw = (F+2)'(l_fx) + (F+2)'(lsf);
        end else begin
            q_raw = (F+2)'(l_fx) + (F+2)'(s_fx) - (F+2)'(lsf);
        end
        q_c = (q_raw > (F+2)'(ONE_W)) ? ONE_W[F:0] : q_raw[F:0];
        l2  = {l_fx, 1'b0};
        p_c = (l2 < q_c) ? '0 : (l2 - q_c);
    end

    // Three times the hue, shifted by one, zero and minus one, with wrap
    assign h3 = {2'b00, h_fx, 1'b0} + {3'b000, h_fx};

    always_comb begin
        t_w[0] = h3 + ONE_W;
        if (t_w[0] > THREE_W) begin
            t_w[0] = t_w[0] - THREE_W;
        end
        t_w[1] = h3;
        t_w[2] = (h3 < ONE_W) ? (h3 + TWO_W) : (h3 - ONE_W);
    end

    // Ramp segment and slope multiplier per channel
    always_comb begin
        w2 = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            w2 = {t_w[k][F+1:0], 1'b0};
            if (w2 < ONE_W) begin
                seg_c[k] = SEG_RISE;
                x_c[k]   = w2[F:0];
            end else if (w2 < THREE_W) begin
                seg_c[k] = SEG_HIGH;
                x_c[k]   = '0;
            end else if (t_w[k] < TWO_W) begin
                seg_c[k] = SEG_FALL;
                x_c[k]   = (FOUR_W - w2) >> 0 == '0 ? '0 : (F+1)'(FOUR_W - w2);
            end else begin
                seg_c[k] = SEG_LOW;
                x_c[k]   = '0;
            end
        end
    end

    // Stage one registers
    always_ff @(posedge aclk) begin
        if (adv1) begin
            p_reg <= p_c;
            q_reg <= q_c;
            d_reg <= q_c - p_c;
            for (int k = 0; k < NUM_CH; k++) begin
                x_reg[k]   <= x_c[k];
                seg_reg[k] <= seg_c[k];
            end
        end
    end

    assign p_o   = p_reg;
    assign q_o   = q_reg;
    assign d_o   = d_reg;
    assign x_o   = x_reg;
    assign seg_o = seg_reg;

endmodule

// ----- rtl/hsl2rgb_ramp.sv -----
// Stages two and three of one channel: ramp product, then scale by 255 and truncate.
`timescale 1ns / 1ps
module hsl2rgb_ramp
    import hsl2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                   aclk,
    input  stage_ctl_t             ctl,
    input  logic [FRACTION_BITS:0] p_i,
    input  logic [FRACTION_BITS:0] q_i,
    input  logic [FRACTION_BITS:0] d_i,
    input  logic [FRACTION_BITS:0] x_i,
    input  hue_seg_t               seg_i,
    output chan_t                  chan_o
);

    localparam int F = FRACTION_BITS;

    logic [F:0]       base_next, base_reg;
    logic [2*F+1:0]   prod_next, prod_reg;
    logic [2*F+1:0]   num;
    logic [2*F+9:0]   num255;
    logic [8:0]       val9;
    chan_t            chan_next, chan_reg;

    // Stage two: flat level and slope product
    assign base_next = (seg_i == SEG_HIGH) ? q_i : p_i;
    assign prod_next = (2*F+2)'(d_i * x_i);

    always_ff @(posedge aclk) begin
        if (ctl.adv2) begin
            base_reg <= base_next;
            prod_reg <= prod_next;
        end
    end

    // Stage three: 255 times the ramp value, truncated
    always_comb begin
        num    = {base_reg, {F{1'b0}}} + prod_reg;
        num255 = {num, 8'h00} - (2*F+10)'(num);
        val9   = num255[2*F+8:2*F];
        chan_next = (val9 > 9'd255) ? 8'hff : val9[7:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv3) begin
            chan_reg <= chan_next;
        end
    end

    assign chan_o = chan_reg;

endmodule

// ----- rtl/hsl_to_rgb_converter_top.sv -----
// Top level of the HSL to RGB converter: valid pipeline and channel instances.
// Three registered stages; throughput is one pixel per cycle unless m_ready stalls.
// A stage moves whenever it is empty or the next one moves.
// Stalls on m_ready back up stage by stage; bubbles are filled while stalled.
// Reset (aresetn low, synchronous) clears the stage valid bits; data registers keep no reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hsl_to_rgb_converter_top
    import hsl2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  chan_t s_hue,
    input  chan_t s_saturation,
    input  chan_t s_lightness,
    output logic  m_valid,
    input  logic  m_ready,
    output chan_t m_red,
    output chan_t m_green,
    output chan_t m_blue
);

    localparam int F = FRACTION_BITS;
    localparam logic [F:0] ONE_FX = (F+1)'(1) << F;

    logic       v1_reg, v1_next;
    logic       v2_reg, v2_next;
    logic       v3_reg, v3_next;
    logic       adv1, adv2, adv3;
    stage_ctl_t ctl;

    logic [F:0] p_w, q_w, d_w;
    logic [F:0] x_w   [NUM_CH];
    hue_seg_t   seg_w [NUM_CH];
    chan_t      chan_w [NUM_CH];

    // Stage advance: a stage loads when empty or when its content moves on
    assign adv3 = !v3_reg || m_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign ctl  = '{adv2: adv2, adv3: adv3};

    assign s_ready = adv1;
    assign m_valid = v3_reg;

    // Valid bits follow the data
    always_comb begin
        v1_next = adv1 ? s_valid : v1_reg;
        v2_next = adv2 ? v1_reg  : v2_reg;
        v3_next = adv3 ? v2_reg  : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    hsl2rgb_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .aclk       (aclk),
        .adv1       (adv1),
        .hue        (s_hue),
        .saturation (s_saturation),
        .lightness  (s_lightness),
        .p_o        (p_w),
        .q_o        (q_w),
        .d_o        (d_w),
        .x_o        (x_w),
        .seg_o      (seg_w)
    );

    // One ramp per color channel: red, green, blue
    for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
        hsl2rgb_ramp #(
            .FRACTION_BITS(FRACTION_BITS)
        ) u_ramp (
            .aclk   (aclk),
            .ctl    (ctl),
            .p_i    (p_w),
            .q_i    (q_w),
            .d_i    (d_w),
            .x_i    (x_w[k]),
            .seg_i  (seg_w[k]),
            .chan_o (chan_w[k])
        );
    end

    assign m_red   = chan_w[0];
    assign m_green = chan_w[1];
    assign m_blue  = chan_w[2];

    // Checks on the pipeline control and stage-one arithmetic
    `ASSERT_CLK(a_accept_fills_s1, aclk, aresetn, (s_valid && s_ready) |=> v1_reg, "transfer lost")
    `ASSERT_CLK(a_s1_holds, aclk, aresetn, (v1_reg && !adv2) |=> (v1_reg && $stable(q_w) && $stable(p_w)), "stalled stage one lost its item")
    `ASSERT_CLK(a_qp_order, aclk, aresetn, v1_reg |-> ((q_w >= p_w) && (q_w <= ONE_FX) && (d_w == q_w - p_w)), "q/p out of range in stage one")
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (!v1_reg && !v2_reg && !m_valid), "pipeline not empty after reset")

endmodule

// ----- bench/tb_hsl_to_rgb_converter_top.sv -----
// Self-checking testbench for the HSL to RGB converter top level.
`timescale 1ns / 1ps
module tb_hsl_to_rgb_converter_top
    import hsl2rgb_pkg::*;
();

    localparam int     FRAC_BITS = 16;
    localparam longint FX_ONE    = 64'sd1 << FRAC_BITS;
    localparam int     PIPE_LAT  = 3;

    typedef struct {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_rgb_t;

    logic  aclk         = 1'b0;
    logic  aresetn      = 1'b0;
    logic  s_valid      = 1'b0;
    logic  s_ready;
    chan_t s_hue        = '0;
    chan_t s_saturation = '0;
    chan_t s_lightness  = '0;
    logic  m_valid;
    logic  m_ready      = 1'b0;
    chan_t m_red;
    chan_t m_green;
    chan_t m_blue;

    pixel_rgb_t expected_rgb[$];
    int         mismatch_count = 0;
    bit         send_gaps_on   = 1'b0;
    bit         recv_stalls_on = 1'b0;

    hsl_to_rgb_converter_top #(
        .FRACTION_BITS(FRAC_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_hue       (s_hue),
        .s_saturation(s_saturation),
        .s_lightness (s_lightness),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue)
    );

    // Clock and reset
    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Hard limit on run length
    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

    // Ramp for one channel; t3 is three times the shifted hue in fixed point.
    // Returns 255 * level, truncated.
    function automatic longint ramp_level(longint p, longint q, longint t3);
        longint num;
        longint val;
        if (2 * t3 < FX_ONE)
            num = p * FX_ONE + (q - p) * (2 * t3);
        else if (2 * t3 < 3 * FX_ONE)
            num = q * FX_ONE;
        else if (t3 < 2 * FX_ONE)
            num = p * FX_ONE + (q - p) * (4 * FX_ONE - 2 * t3);
        else
            num = p * FX_ONE;
        if (num < 0)
            num = 0;
        val = (num * 255) >>> (2 * FRAC_BITS);
        if (val > 255)
            val = 255;
        return val;
    endfunction

    // Fold a tripled hue back into 0..3 (exactly 3 stays)
    function automatic longint wrap_hue(longint t3);
        if (t3 < 0)
            t3 += 3 * FX_ONE;
        if (t3 > 3 * FX_ONE)
            t3 -= 3 * FX_ONE;
        return t3;
    endfunction

    function automatic pixel_rgb_t predict_rgb(chan_t hue, chan_t sat, chan_t light);
        longint     h;
        longint     s;
        longint     l;
        longint     q;
        longint     p;
        pixel_rgb_t px;
        h = longint'(hue) << (FRAC_BITS - 8);
        s = longint'(sat) << (FRAC_BITS - 8);
        l = longint'(light) << (FRAC_BITS - 8);
        // q from lightness and saturation, p mirrored around l
        if (2 * l < FX_ONE)
            q = (l * (FX_ONE + s)) >>> FRAC_BITS;
        else
            q = l + s - ((l * s) >>> FRAC_BITS);
        if (q > FX_ONE)
            q = FX_ONE;
        p = 2 * l - q;
        if (p < 0)
            p = 0;
        px.red   = chan_t'(ramp_level(p, q, wrap_hue(3 * h + FX_ONE)));
        px.green = chan_t'(ramp_level(p, q, wrap_hue(3 * h)));
        px.blue  = chan_t'(ramp_level(p, q, wrap_hue(3 * h - FX_ONE)));
        return px;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR at %0t ns: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= !(recv_stalls_on && ($urandom_range(99) < 15));
    end

    // Record accepted pixels and check each result transfer
    always @(posedge aclk) begin : check_results
        pixel_rgb_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_rgb.insert(expected_rgb.size(),
                                    predict_rgb(s_hue, s_saturation, s_lightness));
            if (m_valid && m_ready) begin
                if (expected_rgb.size() == 0) begin
                    report_mismatch("result with nothing pending, red", m_red, -1);
                end else begin
                    want = expected_rgb.pop_front();
                    if (m_red !== want.red)
                        report_mismatch("red", m_red, want.red);
                    if (m_green !== want.green)
                        report_mismatch("green", m_green, want.green);
                    if (m_blue !== want.blue)
                        report_mismatch("blue", m_blue, want.blue);
                end
            end
        end
    end

    // One input transfer, with an optional idle gap ahead of it
    task automatic send_pixel(chan_t hue, chan_t sat, chan_t light);
        if (send_gaps_on && ($urandom_range(99) < 15)) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= hue;
        s_saturation <= sat;
        s_lightness  <= light;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Let the last transfer be recorded before watching the queue empty
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_rgb.size() != 0)
            @(posedge aclk);
    endtask

    // Field extremes, gray, lightness around one half, hue at breakpoints
    task automatic test_directed();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd128, 8'd0, 8'd128);
        send_pixel(8'd0, 8'd255, 8'd127);
        send_pixel(8'd0, 8'd255, 8'd128);
        send_pixel(8'd0, 8'd128, 8'd127);
        send_pixel(8'd0, 8'd128, 8'd128);
        send_pixel(8'd43, 8'd255, 8'd128);
        send_pixel(8'd85, 8'd255, 8'd128);
        send_pixel(8'd128, 8'd255, 8'd128);
        send_pixel(8'd170, 8'd255, 8'd128);
        send_pixel(8'd171, 8'd255, 8'd128);
        send_pixel(8'd213, 8'd255, 8'd128);
        send_pixel(8'd255, 8'd255, 8'd128);
        send_pixel(8'd42, 8'd200, 8'd64);
        send_pixel(8'd86, 8'd200, 8'd192);
        send_pixel(8'd127, 8'd1, 8'd1);
        send_pixel(8'd1, 8'd254, 8'd254);
        send_pixel(8'd170, 8'd170, 8'd85);
        send_pixel(8'd85, 8'd85, 8'd170);
        wait_drained();
    endtask

    // Random pixel; a fifth of them pin lightness near its special values
    task automatic send_random_pixel();
        chan_t light;
        light = chan_t'($urandom);
        if ($urandom_range(99) < 20) begin
            case ($urandom_range(3))
                0: light = 8'd0;
                1: light = 8'd127;
                2: light = 8'd128;
                default: light = 8'd255;
            endcase
        end
        send_pixel(chan_t'($urandom), chan_t'($urandom), light);
    endtask

    // Back-to-back stream, no idling on either side
    task automatic test_full_rate();
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        repeat (300) send_random_pixel();
        wait_drained();
    endtask

    // Random gaps and stalls, with a full drain partway through
    task automatic test_idle_and_stall();
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        repeat (450) send_random_pixel();
        wait_drained();
        repeat (480) send_random_pixel();
        wait_drained();
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
    endtask

    initial begin
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        test_directed();
        test_full_rate();
        test_idle_and_stall();
        repeat (PIPE_LAT + 5) @(posedge aclk);
        if (mismatch_count == 0 && expected_rgb.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
